// ----- rtl/core/bra_pkg.sv -----
// shared types and constants for the bitmap run allocator
// no dependencies; used by bra_word_scan and bitmap_run_allocator_core
package bra_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;
    localparam int IDX_W      = 10;
    localparam int LEN_W      = 11;
    localparam int OP_W       = 3;
    localparam int CFG_W      = 8;
    localparam int POS_W      = 7;

    localparam logic [CFG_W-1:0] MAP_BYTES_RESET = 8'd128;
    localparam logic [LEN_W-1:0] CNT_MAX         = '1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 3'd0,
        OP_TEST       = 3'd1,
        OP_FIND       = 3'd2,
        OP_WRITE      = 3'd3,
        OP_TOGGLE_NEW = 3'd4,
        OP_TOGGLE_OLD = 3'd5
    } t_opcode;

    // summary of one map word for the run search
    typedef struct packed {
        logic             hit;       // a run of the wanted length fits inside the word
        logic [5:0]       hit_pos;   // lowest start of such a run
        logic             all_free;  // all 64 bits of the word are free and inside the map limit
        logic [POS_W-1:0] lead;      // free bits from bit 0 up to the first used bit
        logic [POS_W-1:0] tail;      // free bits from bit 63 down to the last used bit
    } t_scan;

endpackage

// ----- rtl/core/bra_word_scan.sv -----
// run search over one 64-bit map word: in-word run match, edge free counts
// depends on bra_pkg
module bra_word_scan (
    input  logic [bra_pkg::WORD_BITS-1:0] i_word,
    input  logic [bra_pkg::WORD_BITS-1:0] i_vmask,
    input  logic [bra_pkg::POS_W-1:0]     i_len,
    output bra_pkg::t_scan                o_scan
);

    logic [bra_pkg::WORD_BITS-1:0] used;
    logic [bra_pkg::WORD_BITS:0]   free_ext;
    logic [bra_pkg::WORD_BITS:0]   span [bra_pkg::POS_W];
    logic [bra_pkg::WORD_BITS:0]   acc;

    // bits past the map limit count as used
    assign used     = i_word | ~i_vmask;
    assign free_ext = {1'b0, ~used};

    // span[k][i]: bits i .. i+2^k-1 all free
    always_comb begin
        span[0] = free_ext;
        for (int k = 1; k < bra_pkg::POS_W; k++) begin
            span[k] = span[k-1] & (span[k-1] >> (1 << (k-1)));
        end
    end

    // build the run length from its binary digits, each a fixed shift
    always_comb begin
        acc = '1;
        for (int k = 0; k < bra_pkg::POS_W; k++) begin
            if (i_len[k]) begin
                acc = span[k] & (acc >> (1 << k));
            end
        end
    end

    always_comb begin
        o_scan.hit      = (i_len != '0) && (|acc[bra_pkg::WORD_BITS-1:0]);
        o_scan.hit_pos  = '0;
        o_scan.lead     = 7'd64;
        o_scan.tail     = 7'd64;
        o_scan.all_free = (used == '0);
        for (int i = bra_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (acc[i]) begin
                o_scan.hit_pos = 6'(i);
            end
            if (used[i]) begin
                o_scan.lead = 7'(i);
            end
        end
        for (int i = 0; i < bra_pkg::WORD_BITS; i++) begin
            if (used[i]) begin
                o_scan.tail = 7'(bra_pkg::WORD_BITS - 1 - i);
            end
        end
    end

endmodule

// ----- rtl/core/bitmap_run_allocator_core.sv -----
// bitmap slot allocator: bit test/write/toggle and first-fit free run search
// depends on bra_pkg and bra_word_scan
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------------
//  request  | in        | i_in_valid / o_in_stall    | opcode, bit_index, bit_value, run_length
//  result   | out       | o_out_valid / i_out_stall  | found, start_index, bit_state
//  config   | in        | i_cfg_wr_en                | map_bytes (i_cfg_wr_data)
//
// map held in a 64-bit wide memory of ceil(MAP_BITS/64) words, registered read.
// test/write/toggle: read, modify and write back, then result load.
// find run: scans up to ceil(active bits/64) words
//   (16 for 1024 bits), one map word read and checked per cycle.
// clear all: all ceil(MAP_BITS/64) words zeroed, one memory word per cycle.
// after reset a clearing pass over all ceil(MAP_BITS/64) words runs with requests stalled.
// one request at a time; a finished result sits in the output register while the next
//   request is taken.
module bitmap_run_allocator_core #(
    parameter int MAP_BITS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bra_pkg::CFG_W-1:0]      i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bra_pkg::OP_W-1:0]       i_opcode,
    input  logic [bra_pkg::IDX_W-1:0]      i_bit_index,
    input  logic                           i_bit_value,
    input  logic [bra_pkg::LEN_W-1:0]      i_run_length,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_found,
    output logic [bra_pkg::IDX_W-1:0]      o_start_index,
    output logic                           o_bit_state
);

    localparam int NWORDS    = (MAP_BITS + bra_pkg::WORD_BITS - 1) / bra_pkg::WORD_BITS;
    localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LIMW      = $clog2(MAP_BITS + 1);
    localparam int PW        = AW + bra_pkg::WORD_SHIFT;
    localparam int MAX_BYTES = MAP_BITS / 8;
    localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BIT   = 5'b00010,
        S_FIND  = 5'b00100,
        S_CLEAR = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [bra_pkg::CFG_W-1:0]     r_map_bytes;
    logic [bra_pkg::WORD_BITS-1:0] r_mem [NWORDS];
    logic [bra_pkg::WORD_BITS-1:0] r_rd_data;

    bra_pkg::t_opcode              r_op;
    logic [5:0]                    r_sel;
    logic                          r_bit_value;
    logic                          r_idx_ok;
    logic [bra_pkg::LEN_W-1:0]     r_len;
    logic [bra_pkg::LEN_W-1:0]     r_cnt;
    logic [PW-1:0]                 r_run_start;
    logic [LIMW-1:0]               r_rem;
    logic [AW-1:0]                 r_word;
    logic                          r_clr_resp;

    logic                          r_res_found;
    logic [bra_pkg::IDX_W-1:0]     r_res_start;
    logic                          r_res_state;

    logic                          r_out_valid;
    logic                          r_found;
    logic [bra_pkg::IDX_W-1:0]     r_start;
    logic                          r_state_bit;

    logic                          in_acc;
    logic [31:0]                   idx32;
    logic                          in_idx_ok;
    logic [AW-1:0]                 in_word;
    logic [bra_pkg::LEN_W-1:0]     len_norm;
    logic [31:0]                   limit32;
    logic [LIMW-1:0]               limit;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [AW-1:0]                 mem_raddr;
    logic [bra_pkg::WORD_BITS-1:0] mem_wdata;

    logic                          old_bit;
    logic                          new_bit;
    logic                          res_bit;
    logic                          bit_we;

    logic [31:0]                   rem32;
    logic                          rem_full;
    logic [bra_pkg::WORD_BITS-1:0] vmask;
    logic [bra_pkg::POS_W-1:0]     scan_len;
    bra_pkg::t_scan                scan;
    logic [bra_pkg::LEN_W:0]       carry_sum;
    logic                          carry_hit;
    logic [31:0]                   base32;
    logic [31:0]                   word_start32;
    logic [31:0]                   run_start32;
    logic [bra_pkg::LEN_W:0]       cnt_add;
    logic [bra_pkg::LEN_W-1:0]     cnt_free;
    logic [PW-1:0]                 run_start_new;
    logic [LIMW-1:0]               rem_next;
    logic                          out_free;

    // request side
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign idx32      = 32'(i_bit_index);
    assign in_idx_ok  = idx32 < 32'(MAP_BITS);
    assign in_word    = in_idx_ok ? AW'(idx32 >> bra_pkg::WORD_SHIFT) : '0;
    assign len_norm   = (i_run_length == '0) ? 11'd1 : i_run_length;

    // search limit in bits, map size clamped to the storage
    assign limit32 = ((32'(r_map_bytes) > 32'(MAX_BYTES)) ? 32'(MAX_BYTES)
                                                           : 32'(r_map_bytes)) << 3;
    assign limit   = LIMW'(limit32);

    // single-bit read, modify, write back
    assign old_bit = r_rd_data[r_sel];

    always_comb begin
        unique case (r_op)
            bra_pkg::OP_WRITE: new_bit = r_bit_value;
            default:           new_bit = ~old_bit;
        endcase
    end

    always_comb begin
        res_bit = 1'b0;
        bit_we  = 1'b0;
        case (r_op) inside
            bra_pkg::OP_TEST, bra_pkg::OP_TOGGLE_OLD: res_bit = old_bit;
            bra_pkg::OP_TOGGLE_NEW:                   res_bit = ~old_bit;
            default:                                  res_bit = 1'b0;
        endcase
        case (r_op) inside
            bra_pkg::OP_WRITE, bra_pkg::OP_TOGGLE_NEW, bra_pkg::OP_TOGGLE_OLD: bit_we = 1'b1;
            default:                                                           bit_we = 1'b0;
        endcase
        res_bit = res_bit & r_idx_ok;
        bit_we  = bit_we & r_idx_ok;
    end

    // word scan for the run search
    assign rem32    = 32'(r_rem);
    assign rem_full = rem32 >= 32'(bra_pkg::WORD_BITS);
    assign vmask    = rem_full ? '1 : ((64'd1 << rem32[5:0]) - 64'd1);
    assign scan_len = (r_len <= 11'd64) ? r_len[bra_pkg::POS_W-1:0] : '0;

    bra_word_scan u_scan (
        .i_word  (r_rd_data),
        .i_vmask (vmask),
        .i_len   (scan_len),
        .o_scan  (scan)
    );

    // a run carried in from lower words completes in this word
    assign carry_sum     = {1'b0, r_cnt} + 12'(scan.lead);
    assign carry_hit     = carry_sum >= {1'b0, r_len};
    assign base32        = 32'(r_word) << bra_pkg::WORD_SHIFT;
    assign word_start32  = base32 | 32'(scan.hit_pos);
    assign run_start32   = 32'(r_run_start);
    assign cnt_add       = {1'b0, r_cnt} + 12'd64;
    assign cnt_free      = cnt_add[bra_pkg::LEN_W] ? bra_pkg::CNT_MAX
                                                   : cnt_add[bra_pkg::LEN_W-1:0];
    assign run_start_new = PW'(base32 + 32'(bra_pkg::WORD_BITS) - 32'(scan.tail));
    assign rem_next      = rem_full ? LIMW'(rem32 - 32'(bra_pkg::WORD_BITS)) : '0;

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_word;
        mem_wdata = r_rd_data;
        mem_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                mem_raddr = (i_opcode == bra_pkg::OP_FIND) ? '0 : in_word;
            end
            S_BIT: begin
                mem_we           = bit_we;
                mem_wdata[r_sel] = new_bit;
            end
            S_FIND: begin
                mem_raddr = (r_word == LAST_WORD) ? r_word : r_word + AW'(1);
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            default: begin
                mem_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_opcode) inside
                        bra_pkg::OP_CLEAR: n_state = S_CLEAR;
                        bra_pkg::OP_FIND:  n_state = S_FIND;
                        bra_pkg::OP_TEST, bra_pkg::OP_WRITE,
                        bra_pkg::OP_TOGGLE_NEW, bra_pkg::OP_TOGGLE_OLD: n_state = S_BIT;
                        default:           n_state = S_RESP;
                    endcase
                end
            end
            S_BIT: n_state = S_RESP;
            S_FIND: begin
                if (r_rem == '0 || carry_hit || scan.hit) begin
                    n_state = S_RESP;
                end
            end
            S_CLEAR: begin
                if (r_word == LAST_WORD) begin
                    n_state = r_clr_resp ? S_RESP : S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_word      <= '0;
            r_clr_resp  <= 1'b0;
            r_out_valid <= 1'b0;
            r_map_bytes <= bra_pkg::MAP_BYTES_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_map_bytes <= i_cfg_wr_data;
            end
            if (out_free) begin
                r_out_valid <= (r_state == S_RESP);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op        <= bra_pkg::t_opcode'(i_opcode);
                        r_sel       <= i_bit_index[5:0];
                        r_bit_value <= i_bit_value;
                        r_idx_ok    <= in_idx_ok;
                        r_len       <= len_norm;
                        r_cnt       <= '0;
                        r_run_start <= '0;
                        r_rem       <= limit;
                        r_clr_resp  <= 1'b1;
                        r_res_found <= 1'b0;
                        r_res_start <= '0;
                        r_res_state <= 1'b0;
                        if (i_opcode == bra_pkg::OP_FIND || i_opcode == bra_pkg::OP_CLEAR) begin
                            r_word <= '0;
                        end else begin
                            r_word <= in_word;
                        end
                    end
                end
                S_BIT: begin
                    r_res_state <= res_bit;
                end
                S_FIND: begin
                    if (r_rem != '0) begin
                        if (carry_hit) begin
                            r_res_found <= 1'b1;
                            r_res_start <= run_start32[bra_pkg::IDX_W-1:0];
                        end else if (scan.hit) begin
                            r_res_found <= 1'b1;
                            r_res_start <= word_start32[bra_pkg::IDX_W-1:0];
                        end else begin
                            if (scan.all_free) begin
                                r_cnt <= cnt_free;
                            end else begin
                                r_cnt       <= 11'(scan.tail);
                                r_run_start <= run_start_new;
                            end
                            r_rem  <= rem_next;
                            r_word <= r_word + AW'(1);
                        end
                    end
                end
                S_CLEAR: begin
                    if (r_word != LAST_WORD) begin
                        r_word <= r_word + AW'(1);
                    end
                end
                default: begin
                    r_word <= r_word;
                end
            endcase
        end
    end

    // result register, loaded when empty or being taken
    always_ff @(posedge i_clk) begin
        if (out_free && r_state == S_RESP) begin
            r_found     <= r_res_found;
            r_start     <= r_res_start;
            r_state_bit <= r_res_state;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_start_index = r_start;
    assign o_bit_state   = r_state_bit;

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_BIT || r_state == S_CLEAR))
        else $error("map write outside bit update or clear");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

    a_found_no_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> !o_bit_state)
        else $error("run result carries a bit state");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND && r_rem != '0) |-> (32'(r_word) < 32'(NWORDS)))
        else $error("run scan past the last map word");

endmodule
